// ===== rtl/bpa_pkg.sv =====
`default_nettype none

package bpa_pkg;

  // Request opcodes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Bitmap geometry and address constants
  localparam int WORD_BITS  = 32;
  localparam int WORD_SHIFT = 5;
  localparam int PAGE_SHIFT = 12;
  localparam logic [47:0] POOL_BASE_RESET = 48'h00_0001_000000;

  typedef struct packed {
    logic [1:0]  op;
    logic [12:0] page_count;
    logic [47:0] base_address;
  } req_t;

  typedef struct packed {
    logic [47:0] address;
    logic        ok;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic clr_step;
    logic scan_init;
    logic scan_step;
    logic fprep1;
    logic fprep2;
    logic mark_init;
    logic mark_step;
    logic res_done;
    logic res_fail;
    logic rsp_load;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       n_zero;
    logic       clr_last;
    logic       scan_hit;
    logic       scan_miss;
    logic       free_empty;
    logic       mark_done;
    logic       rsp_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/bpa_datapath.sv =====
`default_nettype none

module bpa_datapath #(
  parameter int PAGE_COUNT = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  bpa_pkg::req_t    req,
  input  bpa_pkg::ctl_cmd_t cmd,
  output bpa_pkg::ctl_sts_t sts,
  input  logic             cfg_wr,
  input  logic [47:0]      cfg_data,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output bpa_pkg::rsp_t    rsp
);
  import bpa_pkg::*;

  localparam int WORDS     = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int XW        = WAW + WORD_SHIFT;
  localparam int NW        = $clog2(PAGE_COUNT + 1);
  localparam int EW        = NW + WORD_SHIFT + 1;
  localparam int LAST_BITS = PAGE_COUNT - (WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] PAD_MASK  = {WORD_BITS{1'b1}} << LAST_BITS;
  localparam logic [WAW-1:0]       LAST_WORD = WAW'(WORDS - 1);
  localparam logic [XW-1:0]        LAST_PAGE = XW'(PAGE_COUNT - 1);

  // Used-bit memory, one word of pages per row
  logic [WORD_BITS-1:0] mem [WORDS];

  logic [1:0]           op;
  logic [NW-1:0]        n;
  logic [47:0]          base;
  logic [47:0]          pool_base;
  logic [WAW-1:0]       clr_ptr;
  logic [WAW-1:0]       rd_ptr;
  logic [WAW-1:0]       iss_last;
  logic                 iss_on;
  logic                 rd_valid;
  logic [WAW-1:0]       rd_idx;
  logic [WORD_BITS-1:0] rdata;
  logic [NW-1:0]        carry;
  logic [XW-1:0]        lo;
  logic [XW-1:0]        hi;
  logic                 neg;
  logic [36:0]          ofs;
  logic                 free_empty;
  logic [47:0]          res_addr;
  logic                 res_ok;

  logic [31:0]          pc_ext;
  logic [NW-1:0]        n_next;
  logic                 mem_re;
  logic                 mem_we;
  logic [WAW-1:0]       mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] used_w;
  logic [5:0]           run_l  [WORD_SHIFT+1][WORD_BITS];
  logic                 full_l [WORD_SHIFT+1][WORD_BITS];
  logic [EW-1:0]        eff    [WORD_BITS];
  logic [WORD_BITS-1:0] found;
  logic                 hit;
  logic [4:0]           hit_pos;
  logic [XW-1:0]        hit_hi;
  logic [XW-1:0]        hit_lo;
  logic [NW-1:0]        carry_next;
  logic [WAW-1:0]       lo_w;
  logic [WAW-1:0]       hi_w;
  logic [4:0]           lb;
  logic [4:0]           hb;
  logic [WORD_BITS-1:0] mark_mask;
  logic [WORD_BITS-1:0] mark_wdata;
  logic [48:0]          d_sub;
  logic [48:0]          nd_sub;
  logic [37:0]          fsum;
  logic [37:0]          fdif;

  // Clamp the requested count to the pool size
  assign pc_ext = 32'(req.page_count);
  assign n_next = (pc_ext > 32'(PAGE_COUNT)) ? NW'(PAGE_COUNT) : NW'(pc_ext);

  // Memory port control
  assign mem_re    = (cmd.scan_step || cmd.mark_step) && iss_on;
  assign mem_we    = cmd.clr_step || (cmd.mark_step && rd_valid);
  assign mem_waddr = cmd.clr_step ? clr_ptr : rd_idx;
  assign mem_wdata = cmd.clr_step ? '0 : mark_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[rd_ptr];
    end
  end

  // Pages past the end of the pool look used
  assign used_w = rdata | ((rd_idx == LAST_WORD) ? PAD_MASK : '0);

  // Free-run lengths ending at each bit, built by doubling segments
  always_comb begin
    for (int p = 0; p < WORD_BITS; p++) begin
      run_l[0][p]  = used_w[p] ? 6'd0 : 6'd1;
      full_l[0][p] = !used_w[p];
    end
    for (int k = 0; k < WORD_SHIFT; k++) begin
      for (int p = 0; p < WORD_BITS; p++) begin
        if (p >= (1 << k) && full_l[k][p]) begin
          run_l[k+1][p]  = 6'(1 << k) + run_l[k][p - (1 << k)];
          full_l[k+1][p] = full_l[k][p - (1 << k)];
        end else begin
          run_l[k+1][p]  = run_l[k][p];
          full_l[k+1][p] = full_l[k][p];
        end
      end
    end
  end

  // Extend runs that reach bit 0 by the carry from earlier words
  always_comb begin
    for (int p = 0; p < WORD_BITS; p++) begin
      eff[p]   = full_l[WORD_SHIFT][p] ? (EW'(carry) + EW'(p + 1))
                                       : EW'(run_l[WORD_SHIFT][p]);
      found[p] = (eff[p] >= EW'(n));
    end
  end

  // Lowest bit at which a long enough run ends
  always_comb begin
    hit_pos = '0;
    for (int p = WORD_BITS - 1; p >= 0; p--) begin
      if (found[p]) begin
        hit_pos = 5'(p);
      end
    end
  end

  assign hit        = |found;
  assign hit_hi     = {rd_idx, hit_pos};
  assign hit_lo     = hit_hi + XW'(1) - XW'(n);
  assign carry_next = full_l[WORD_SHIFT][WORD_BITS-1] ?
                      NW'(carry + NW'(WORD_BITS)) : NW'(run_l[WORD_SHIFT][WORD_BITS-1]);

  // Range mask for the word being marked
  assign lo_w = lo[XW-1:WORD_SHIFT];
  assign hi_w = hi[XW-1:WORD_SHIFT];
  assign lb   = (rd_idx == lo_w) ? lo[4:0] : 5'd0;
  assign hb   = (rd_idx == hi_w) ? hi[4:0] : 5'd31;

  always_comb begin
    for (int q = 0; q < WORD_BITS; q++) begin
      mark_mask[q] = (5'(q) >= lb) && (5'(q) <= hb);
    end
  end

  assign mark_wdata = (op == OP_ALLOC) ? (rdata | mark_mask) : (rdata & ~mark_mask);

  // Free range setup arithmetic
  assign d_sub  = {1'b0, base} - {1'b0, pool_base};
  assign nd_sub = {1'b0, pool_base} + 49'd4095 - {1'b0, base};
  assign fsum   = {1'b0, ofs} + 38'(n) - 38'd1;
  assign fdif   = 38'(n) - {1'b0, ofs} - 38'd1;

  // Control registers: sweep pointer, read-issue enable and read-valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr  <= '0;
      iss_on   <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= mem_re;
      if (cmd.clr_step) begin
        clr_ptr <= (clr_ptr == LAST_WORD) ? '0 : clr_ptr + WAW'(1);
      end
      if (cmd.scan_init) begin
        iss_on <= 1'b1;
      end else if (cmd.mark_init) begin
        iss_on <= 1'b1;
      end else if (mem_re && rd_ptr == iss_last) begin
        iss_on <= 1'b0;
      end
    end
  end

  // Issue pointer and scan state
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      rd_ptr   <= '0;
      iss_last <= LAST_WORD;
      carry    <= '0;
    end else if (cmd.mark_init) begin
      rd_ptr   <= lo_w;
      iss_last <= hi_w;
    end else if (mem_re) begin
      rd_ptr <= rd_ptr + WAW'(1);
    end
    if (mem_re) begin
      rd_idx <= rd_ptr;
    end
    if (cmd.scan_step && rd_valid) begin
      if (hit) begin
        lo <= hit_lo;
        hi <= hit_hi;
      end else begin
        carry <= carry_next;
      end
    end else if (cmd.fprep2) begin
      if (!neg) begin
        lo <= XW'(ofs);
        hi <= (fsum >= 38'(PAGE_COUNT)) ? LAST_PAGE : XW'(fsum);
      end else begin
        lo <= '0;
        hi <= XW'(fdif);
      end
    end
  end

  // Request latch and free setup
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= req.op;
      n    <= n_next;
      base <= req.base_address;
    end
    if (cmd.fprep1) begin
      neg <= d_sub[48];
      ofs <= d_sub[48] ? nd_sub[48:12] : {1'b0, d_sub[47:12]};
    end
    if (cmd.fprep2) begin
      free_empty <= neg ? (ofs >= 37'(n)) : (ofs >= 37'(PAGE_COUNT));
    end
  end

  // Pool base register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= POOL_BASE_RESET;
    end else if (cfg_wr) begin
      pool_base <= cfg_data;
    end
  end

  // Result and output register
  always_ff @(posedge clk) begin
    if (cmd.res_done) begin
      res_addr <= (op == OP_ALLOC) ?
                  (pool_base + 48'({lo, {PAGE_SHIFT{1'b0}}})) : '0;
      res_ok   <= 1'b1;
    end else if (cmd.res_fail) begin
      res_addr <= '0;
      res_ok   <= 1'b0;
    end
    if (cmd.rsp_load) begin
      rsp.address <= res_addr;
      rsp.ok      <= res_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Status to controller
  assign sts.op         = op;
  assign sts.n_zero     = (n == '0);
  assign sts.clr_last   = (clr_ptr == LAST_WORD);
  assign sts.scan_hit   = rd_valid && hit;
  assign sts.scan_miss  = rd_valid && !hit && (rd_idx == LAST_WORD);
  assign sts.free_empty = free_empty;
  assign sts.mark_done  = rd_valid && (rd_idx == hi_w);
  assign sts.rsp_free   = !rsp_valid || !rsp_stall;

  a_rsp_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.rsp_load |-> (!rsp_valid || !rsp_stall))
    else $error("result loaded over an unsent beat");

  a_mark_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.mark_step && rd_valid) |-> (rd_idx >= lo_w && rd_idx <= hi_w))
    else $error("mark write outside the run");

  a_hit_in_pool: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_step && rd_valid && hit) |-> (hit_hi <= LAST_PAGE))
    else $error("allocated run ends past the pool");

endmodule

`default_nettype wire

// ===== rtl/bpa_ctrl.sv =====
`default_nettype none

module bpa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  bpa_pkg::ctl_sts_t  sts,
  output bpa_pkg::ctl_cmd_t  cmd
);
  import bpa_pkg::*;

  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DECODE = 4'd2;
  localparam logic [3:0] ST_CLR    = 4'd3;
  localparam logic [3:0] ST_SCAN   = 4'd4;
  localparam logic [3:0] ST_FPREP1 = 4'd5;
  localparam logic [3:0] ST_FPREP2 = 4'd6;
  localparam logic [3:0] ST_FCHK   = 4'd7;
  localparam logic [3:0] ST_MINIT  = 4'd8;
  localparam logic [3:0] ST_MARK   = 4'd9;
  localparam logic [3:0] ST_RESP   = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Sequence one request at a time
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts.op)
          OP_ALLOC: begin
            if (sts.n_zero) begin
              cmd.res_fail = 1'b1;
              state_next   = ST_RESP;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = ST_SCAN;
            end
          end
          OP_FREE: begin
            if (sts.n_zero) begin
              cmd.res_fail = 1'b1;
              state_next   = ST_RESP;
            end else begin
              state_next = ST_FPREP1;
            end
          end
          OP_CLEAR: state_next = ST_CLR;
          default: begin
            cmd.res_fail = 1'b1;
            state_next   = ST_RESP;
          end
        endcase
      end
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          cmd.res_done = 1'b1;
          state_next   = ST_RESP;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit) begin
          state_next = ST_MINIT;
        end else if (sts.scan_miss) begin
          cmd.res_fail = 1'b1;
          state_next   = ST_RESP;
        end
      end
      ST_FPREP1: begin
        cmd.fprep1 = 1'b1;
        state_next = ST_FPREP2;
      end
      ST_FPREP2: begin
        cmd.fprep2 = 1'b1;
        state_next = ST_FCHK;
      end
      ST_FCHK: begin
        if (sts.free_empty) begin
          cmd.res_done = 1'b1;
          state_next   = ST_RESP;
        end else begin
          cmd.mark_init = 1'b1;
          state_next    = ST_MARK;
        end
      end
      ST_MINIT: begin
        cmd.mark_init = 1'b1;
        state_next    = ST_MARK;
      end
      ST_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_done) begin
          cmd.res_done = 1'b1;
          state_next   = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts.rsp_free) begin
          cmd.rsp_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign req_stall = (state != ST_IDLE);

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == ST_DECODE))
    else $error("accepted beat not decoded");

  a_mark_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARK && sts.mark_done) |=> (state == ST_RESP))
    else $error("mark sweep did not finish");

  a_scan_exclusive: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !(sts.scan_hit && sts.scan_miss))
    else $error("scan reported hit and miss together");

endmodule

`default_nettype wire

// ===== rtl/bitmap_page_allocator.sv =====
`default_nettype none

// Allocate scans the bitmap word by word up to the first fit, then marks each word of the run;
//   free sets up the range and then clears each word it touches; clear sweeps every word.
// Throughput: one request at a time; the sweep over 32-bit words, one per cycle, sets the time.
// Reset: the bitmap is zeroed by a sweep over every word before the first request is
//   accepted; pool_base resets to 0x01000000, config writes are taken at once.
module bitmap_page_allocator #(
  parameter int PAGE_COUNT = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bpa_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bpa_pkg::rsp_t  rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [47:0]    cfg_data
);
  import bpa_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpa_datapath #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import bpa_pkg::*;

  localparam int          PAGES      = 4096;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam logic [63:0] PAGE_BYTES = 64'h1000;

  typedef struct {
    int first;
    int count;
  } run_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [47:0] cfg_data = '0;

  // Allocator shadow state
  bit          used_map [PAGES];
  logic [47:0] pool_base = POOL_BASE_RESET;
  run_t        live_runs [$];

  req_t        req_queue [$];
  rsp_t        expected_rsp [$];
  logic        req_fired = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          errors = 0;

  bitmap_page_allocator #(.PAGE_COUNT(PAGES)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the shadow bitmap and return the response it must give
  function automatic rsp_t apply_request(req_t r);
    rsp_t        res;
    int          n;
    int          start;
    int          len;
    bit          found;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] a;
    res = '0;
    n = (r.page_count > PAGES) ? PAGES : int'(r.page_count);
    lo = {16'b0, pool_base};
    hi = lo + 64'(PAGES) * PAGE_BYTES;
    case (r.op)
      OP_ALLOC: begin
        if (n != 0) begin
          // First fit: lowest run of n free pages
          len = 0;
          start = 0;
          found = 1'b0;
          for (int i = 0; i < PAGES && !found; i++) begin
            if (used_map[i]) begin
              len = 0;
            end else begin
              if (len == 0) start = i;
              len++;
              if (len == n) found = 1'b1;
            end
          end
          if (found) begin
            for (int j = start; j < start + n; j++) used_map[j] = 1'b1;
            res.address = pool_base + (48'(start) << PAGE_SHIFT);
            res.ok = 1'b1;
            live_runs.push_back('{start, n});
          end
        end
      end
      OP_FREE: begin
        if (n != 0) begin
          // Page addresses are formed without wrap; skip anything off the pool
          for (int i = 0; i < n; i++) begin
            a = {16'b0, r.base_address} + 64'(i) * PAGE_BYTES;
            if (a >= lo && a < hi) used_map[int'((a - lo) >> PAGE_SHIFT)] = 1'b0;
          end
          res.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        foreach (used_map[i]) used_map[i] = 1'b0;
        live_runs.delete();
        res.ok = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic req_t make_req(logic [1:0] op, logic [12:0] count, logic [47:0] base);
    req_t r;
    r.op = op;
    r.page_count = count;
    r.base_address = base;
    return r;
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // Mostly small runs, some large, a few zero or oversized
  function automatic logic [12:0] pick_count();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 13'($urandom_range(1, 16));
    if (p < 90) return 13'($urandom_range(17, 256));
    if (p < 96) return 13'($urandom_range(257, PAGES));
    if (p < 98) return 13'd0;
    return 13'($urandom_range(PAGES + 1, 8191));
  endfunction

  task automatic make_random_req(output req_t r);
    int          p;
    int          k;
    run_t        run;
    logic [47:0] off;
    p = $urandom_range(99);
    off = 48'($urandom_range(4095));
    r = make_req(OP_ALLOC, pick_count(), rand48());
    if (p >= 52 && p < 94) begin
      r.op = OP_FREE;
      if (live_runs.size() > 0 && $urandom_range(99) < 70) begin
        // Return a run that is really held, sometimes only part of it
        k = $urandom_range(live_runs.size() - 1);
        run = live_runs[k];
        live_runs.delete(k);
        r.base_address = pool_base + (48'(run.first) << PAGE_SHIFT) + off;
        r.page_count = ($urandom_range(99) < 80) ? 13'(run.count)
                                                 : 13'($urandom_range(1, run.count));
      end else begin
        case ($urandom_range(3))
          0: r.base_address = pool_base + (48'($urandom_range(PAGES - 1)) << PAGE_SHIFT) + off;
          1: r.base_address = pool_base - (48'($urandom_range(1, 64)) << PAGE_SHIFT) + off;
          2: r.base_address = rand48();
          default: r.base_address = pool_base +
                                    (48'($urandom_range(PAGES - 100, PAGES + 100)) << PAGE_SHIFT);
        endcase
      end
    end else if (p >= 94 && p < 97) begin
      r.op = OP_CLEAR;
    end else if (p >= 97) begin
      r.op = OP_UNUSED;
    end
  endtask

  // Request driver: present the next queued beat once the last one is taken
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fired) begin
      if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req <= req_queue.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response backpressure
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: predict on each accepted request, check each accepted response
  always @(posedge clk) begin
    rsp_t want;
    req_fired <= !rst && req_valid && !req_stall;
    if (!rst && req_valid && !req_stall) expected_rsp.push_back(apply_request(req));
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: response with none expected: address %h ok %b",
                 $time, rsp.address, rsp.ok);
        errors++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.address !== want.address) begin
          $display("%0t: address mismatch: expected %h actual %h",
                   $time, want.address, rsp.address);
          errors++;
        end
        if (rsp.ok !== want.ok) begin
          $display("%0t: ok mismatch: expected %b actual %b", $time, want.ok, rsp.ok);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    @(posedge clk);
    while (req_queue.size() != 0 || req_valid || expected_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_pool_base(input logic [47:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pool_base = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Feed a phase of random requests, keeping the queue short so frees track live runs
  task automatic run_phase(input int items, input int idle, input int stall, input bit pause);
    req_t r;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int k = 0; k < items; k++) begin
      while (req_queue.size() >= 2) @(posedge clk);
      if (pause && k == items / 2) wait_drained();
      make_random_req(r);
      req_queue.push_back(r);
    end
    wait_drained();
  endtask

  initial begin
    logic [47:0] pb;
    pb = POOL_BASE_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero counts, full pool, clamping, out-of-pool frees, first fit, unused op
    req_queue.push_back(make_req(OP_ALLOC, 13'd0, 48'd0));
    req_queue.push_back(make_req(OP_FREE, 13'd0, pb));
    req_queue.push_back(make_req(OP_ALLOC, 13'd1, 48'd0));
    req_queue.push_back(make_req(OP_ALLOC, 13'd4096, 48'd0));
    req_queue.push_back(make_req(OP_CLEAR, 13'd0, 48'd0));
    req_queue.push_back(make_req(OP_ALLOC, 13'd4096, 48'hFFFF_FFFF_FFFF));
    req_queue.push_back(make_req(OP_ALLOC, 13'd1, 48'd0));
    req_queue.push_back(make_req(OP_FREE, 13'h1FFF, pb));
    req_queue.push_back(make_req(OP_ALLOC, 13'h1FFF, 48'd0));
    req_queue.push_back(make_req(OP_FREE, 13'd5, 48'd0));
    req_queue.push_back(make_req(OP_FREE, 13'd10, pb + (48'd4094 << PAGE_SHIFT) + 48'h123));
    req_queue.push_back(make_req(OP_ALLOC, 13'd2, 48'd0));
    req_queue.push_back(make_req(OP_ALLOC, 13'd1, 48'd0));
    req_queue.push_back(make_req(OP_FREE, 13'd4096, 48'hFFFF_FFFF_FFFF));
    req_queue.push_back(make_req(OP_CLEAR, 13'h1FFF, 48'hFFFF_FFFF_FFFF));
    req_queue.push_back(make_req(OP_ALLOC, 13'd3, 48'd0));
    req_queue.push_back(make_req(OP_ALLOC, 13'd5, 48'd0));
    req_queue.push_back(make_req(OP_ALLOC, 13'd7, 48'd0));
    req_queue.push_back(make_req(OP_FREE, 13'd5, pb + (48'd3 << PAGE_SHIFT)));
    req_queue.push_back(make_req(OP_ALLOC, 13'd6, 48'd0));
    req_queue.push_back(make_req(OP_ALLOC, 13'd4, 48'd0));
    req_queue.push_back(make_req(OP_ALLOC, 13'd1, 48'd0));
    req_queue.push_back(make_req(OP_UNUSED, 13'h1FFF, 48'hFFFF_FFFF_FFFF));
    req_queue.push_back(make_req(OP_UNUSED, 13'd1, 48'd0));
    wait_drained();

    // Random phases over several pool bases and idle patterns
    write_pool_base(48'h0);
    run_phase(280, 0, 0, 1'b0);
    write_pool_base(48'hFFFF_FFFF_FFFF);
    run_phase(280, 65, 0, 1'b0);
    write_pool_base(rand48());
    run_phase(280, 0, 65, 1'b0);
    write_pool_base(48'hFFFF_FF80_0000);
    run_phase(280, 33, 33, 1'b0);
    write_pool_base(POOL_BASE_RESET);
    run_phase(280, 0, 0, 1'b1);

    // Let any stray response show up
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bpa_pkg.sv
rtl/bpa_datapath.sv
rtl/bpa_ctrl.sv
rtl/bitmap_page_allocator.sv
bench/tb.sv
